@@ sv/pbnf_pkg.sv @@
// shared constants, types and codes for the page bitmap next-fit allocator
package pbnf_pkg;

  // sizing
  localparam int PAGE_TOTAL     = 32768;
  localparam int PAGE_BYTES_LOG = 12;
  localparam int KERNEL_BYTES   = 16 * 1024 * 1024;

  // fixed field widths
  localparam int REG_W     = 16;
  localparam int SIZE_W    = 28;
  localparam int ALIGN_W   = 4;
  localparam int ADDR_W    = 27;
  localparam int CFG_IDX_W = 1;

  // page map word organisation
  localparam int WORD_W = (PAGE_TOTAL < 64) ? 16 : 64;
  localparam int WB     = $clog2(WORD_W);
  localparam int NWORDS = (PAGE_TOTAL + WORD_W - 1) / WORD_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  // internal widths
  localparam int LW = $clog2(PAGE_TOTAL);
  localparam int PW = $clog2(PAGE_TOTAL + 32768) + 1;
  localparam int CW = SIZE_W - PAGE_BYTES_LOG + 1;
  localparam int TW = CW + 1;
  localparam int EW = ((PW > CW) ? PW : CW) + 1;

  // reset values
  localparam int REG_MAX       = (1 << REG_W) - 1;
  localparam int USABLE_RST    = (PAGE_TOTAL > REG_MAX + 1) ? REG_MAX : PAGE_TOTAL;
  localparam int RES_PAGES     = KERNEL_BYTES >> PAGE_BYTES_LOG;
  localparam int RESERVED_RST  = (RES_PAGES > REG_MAX) ? REG_MAX : RES_PAGES;
  localparam int RES_CLAMP_RST = (RESERVED_RST > PAGE_TOTAL) ? PAGE_TOTAL : RESERVED_RST;
  localparam int LAST_END_RST  = (RES_CLAMP_RST == 0) ? PAGE_TOTAL - 1 : RES_CLAMP_RST - 1;

  // request kinds
  localparam logic KIND_REINIT = 1'b0;
  localparam logic KIND_ALLOC  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ALLOC,
    ST_CHK,
    ST_WAIT,
    ST_EVAL,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_REINIT,
    RES_ALLOC
  } res_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic scan_init;
    logic scan_second;
    logic scan_rd;
    logic scan_cap;
    logic scan_step;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic res_set;
    res_t res_code;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic cnt_zero;
    logic pos_ge_hi;
    logic fit;
    logic mark_last;
  } stat_t;

endpackage

@@ sv/pbnf_ram.sv @@
// generic simple dual-port ram with registered read
module pbnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pbnf_datapath.sv @@
// page map, search registers, configuration and result registers
module pbnf_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbnf_pkg::cmd_t                    cmd,
  output pbnf_pkg::stat_t                   stat,
  input  logic                              cfg_wr,
  input  logic [pbnf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbnf_pkg::REG_W-1:0]        cfg_data,
  input  logic [pbnf_pkg::SIZE_W-1:0]       in_size_bytes,
  input  logic [pbnf_pkg::ALIGN_W-1:0]      in_align_log,
  output logic                              out_found,
  output logic [pbnf_pkg::ADDR_W-1:0]       out_address
);
  import pbnf_pkg::*;

  function automatic logic [PW-1:0] clamp_pages(logic [REG_W-1:0] v);
    logic [PW-1:0] ext;
    ext = PW'(v);
    return (ext > PW'(PAGE_TOTAL)) ? PW'(PAGE_TOTAL) : ext;
  endfunction

  // configuration
  logic [REG_W-1:0] usable_r, reserved_r;

  // request
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] amask_r;
  logic [CW-1:0] cnt_nxt;
  logic [PW-1:0] amask_nxt;
  logic [SIZE_W:0] size_sum;

  // clearing sweep
  logic [PW-1:0] clr_lim_r, clr_lim_nxt;
  logic [AW-1:0] wcnt_r;
  logic [LW-1:0] last_end_r;
  logic [WORD_W-1:0] clr_word;

  // search
  logic [PW-1:0] pos_r, cand_r, hi_r;
  logic [TW-1:0] run_r;
  logic          has_r;
  logic [WB-1:0] u_r;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] iso;
  logic [WB-1:0] enc;
  logic [WB:0]   free_lim, free_here;
  logic [TW-1:0] total;
  logic [PW-1:0] fail_page, restart;

  // marking
  logic [LW-1:0] mstart_r, mend_r, mend_nxt;
  logic [AW-1:0] mw_r, mark_sw, mark_ew;
  logic [WORD_W-1:0] mark_mask;

  // result
  logic          res_found_r;
  logic [LW-1:0] res_start_r;
  logic          out_found_r;
  logic [ADDR_W-1:0] out_address_r;

  // memory
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  pbnf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request decode
  always_comb begin
    size_sum  = {1'b0, in_size_bytes} + (SIZE_W + 1)'((1 << PAGE_BYTES_LOG) - 1);
    cnt_nxt   = size_sum[SIZE_W:PAGE_BYTES_LOG];
    amask_nxt = (PW'(1) << in_align_log) - PW'(1);
  end

  // reinitialise word for the sweep
  always_comb begin
    logic [PW-1:0] lim_w;
    logic [WB-1:0] lim_b;
    lim_w = clr_lim_r >> WB;
    lim_b = clr_lim_r[WB-1:0];
    for (int j = 0; j < WORD_W; j++) begin
      clr_word[j] = (PW'(wcnt_r) < lim_w) || ((PW'(wcnt_r) == lim_w) && (WB'(j) < lim_b));
    end
  end

  assign clr_lim_nxt = clamp_pages(reserved_r);

  // word examination: pages below the position ignored, pages at or above hi seen as used
  always_comb begin
    logic [PW-1:0] cw, hw;
    logic [WB-1:0] hb, off;
    cw  = pos_r >> WB;
    hw  = hi_r >> WB;
    hb  = hi_r[WB-1:0];
    off = pos_r[WB-1:0];
    for (int j = 0; j < WORD_W; j++) begin
      masked[j] = (ram_rdata[j] || (cw > hw) || ((cw == hw) && (WB'(j) >= hb)))
                  && (WB'(j) >= off);
    end
    iso = masked & (~masked + WORD_W'(1));
    enc = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (iso[j]) begin
        enc = enc | WB'(j);
      end
    end
  end

  // run accounting
  always_comb begin
    free_lim  = has_r ? {1'b0, u_r} : (WB + 1)'(WORD_W);
    free_here = free_lim - {1'b0, pos_r[WB-1:0]};
    total     = run_r + TW'(free_here);
    fail_page = {pos_r[PW-1:WB], u_r};
    restart   = (fail_page | amask_r) + PW'(1);
    mend_nxt  = LW'(EW'(cand_r) + EW'(cnt_r) - EW'(1));
  end

  // marking mask over the current word
  always_comb begin
    logic [WB-1:0] lo_b, hi_b;
    mark_sw = AW'(mstart_r >> WB);
    mark_ew = AW'(mend_r >> WB);
    lo_b = (mw_r == mark_sw) ? mstart_r[WB-1:0] : '0;
    hi_b = (mw_r == mark_ew) ? mend_r[WB-1:0] : '1;
    for (int j = 0; j < WORD_W; j++) begin
      mark_mask[j] = (WB'(j) >= lo_b) && (WB'(j) <= hi_b);
    end
  end

  // memory port selection
  always_comb begin
    ram_we    = cmd.clr_step | cmd.mark_wr;
    ram_waddr = cmd.clr_step ? wcnt_r : mw_r;
    ram_wdata = cmd.clr_step ? clr_word : (ram_rdata | mark_mask);
    ram_re    = cmd.scan_rd | cmd.mark_rd;
    ram_raddr = cmd.scan_rd ? AW'(pos_r >> WB) : mw_r;
  end

  always_comb begin
    stat            = '0;
    stat.sweep_last = (wcnt_r == AW'(NWORDS - 1));
    stat.cnt_zero   = (cnt_r == '0);
    stat.pos_ge_hi  = (pos_r >= hi_r);
    stat.fit        = (total >= TW'(cnt_r));
    stat.mark_last  = (mw_r == mark_ew);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r   <= REG_W'(USABLE_RST);
      reserved_r <= REG_W'(RESERVED_RST);
      clr_lim_r  <= PW'(RES_CLAMP_RST);
      wcnt_r     <= '0;
      last_end_r <= LW'(LAST_END_RST);
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_USABLE:   usable_r   <= cfg_data;
          CFG_RESERVED: reserved_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_start) begin
        clr_lim_r  <= clr_lim_nxt;
        wcnt_r     <= '0;
        last_end_r <= (clr_lim_nxt == '0) ? LW'(PAGE_TOTAL - 1) : LW'(clr_lim_nxt - PW'(1));
      end else if (cmd.clr_step) begin
        wcnt_r <= wcnt_r + AW'(1);
      end
      if (cmd.mark_start) begin
        last_end_r <= mend_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r   <= cnt_nxt;
      amask_r <= amask_nxt;
    end
    if (cmd.scan_init) begin
      if (cmd.scan_second) begin
        cand_r <= '0;
        pos_r  <= '0;
        hi_r   <= PW'(last_end_r);
      end else begin
        cand_r <= (PW'(last_end_r) | amask_r) + PW'(1);
        pos_r  <= (PW'(last_end_r) | amask_r) + PW'(1);
        hi_r   <= clamp_pages(usable_r);
      end
      run_r <= '0;
    end else if (cmd.scan_step) begin
      if (has_r) begin
        cand_r <= restart;
        pos_r  <= restart;
        run_r  <= '0;
      end else begin
        pos_r <= {pos_r[PW-1:WB] + (PW - WB)'(1), {WB{1'b0}}};
        run_r <= total;
      end
    end
    if (cmd.scan_cap) begin
      has_r <= |masked;
      u_r   <= enc;
    end
    if (cmd.mark_start) begin
      mstart_r <= LW'(cand_r);
      mend_r   <= mend_nxt;
      mw_r     <= AW'(cand_r >> WB);
    end else if (cmd.mark_wr) begin
      mw_r <= mw_r + AW'(1);
    end
    if (cmd.res_set) begin
      res_found_r <= (cmd.res_code != RES_FAIL);
      res_start_r <= (cmd.res_code == RES_ALLOC) ? LW'(cand_r) : '0;
    end
    if (cmd.out_load) begin
      out_found_r   <= res_found_r;
      out_address_r <= ADDR_W'({res_start_r, {PAGE_BYTES_LOG{1'b0}}});
    end
  end

  assign out_found   = out_found_r;
  assign out_address = out_address_r;

endmodule

@@ sv/pbnf_ctrl.sv @@
// sequencing state machine for sweep, search, marking and result transfer
module pbnf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pbnf_pkg::stat_t stat,
  output pbnf_pkg::cmd_t  cmd
);
  import pbnf_pkg::*;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    case (state_r)
      ST_INIT: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_REINIT) ? ST_CLEAR : ST_ALLOC;
        end
      end
      ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_RESP;
      end
      ST_ALLOC: begin
        second_nxt = 1'b0;
        state_nxt  = stat.cnt_zero ? ST_RESP : ST_CHK;
      end
      ST_CHK: begin
        if (stat.pos_ge_hi) begin
          if (!second_r) begin
            second_nxt = 1'b1;
          end else begin
            state_nxt = ST_RESP;
          end
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT:    state_nxt = ST_EVAL;
      ST_EVAL:    state_nxt = stat.fit ? ST_MARK_RD : ST_CHK;
      ST_MARK_RD: state_nxt = ST_MARK_WR;
      ST_MARK_WR: state_nxt = stat.mark_last ? ST_RESP : ST_MARK_RD;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
    out_valid_nxt = ((state_r == ST_RESP) && out_free) ? 1'b1 :
                    (out_ready ? 1'b0 : out_valid_r);
  end

  // outputs and datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_INIT: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_REINIT) cmd.clr_start = 1'b1;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RES_REINIT;
        end
      end
      ST_ALLOC: begin
        if (stat.cnt_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = RES_FAIL;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      ST_CHK: begin
        if (stat.pos_ge_hi) begin
          if (!second_r) begin
            cmd.scan_init   = 1'b1;
            cmd.scan_second = 1'b1;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = RES_FAIL;
          end
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_WAIT: cmd.scan_cap = 1'b1;
      ST_EVAL: begin
        if (stat.fit) begin
          cmd.mark_start = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_code   = RES_ALLOC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MARK_RD: cmd.mark_rd = 1'b1;
      ST_MARK_WR: cmd.mark_wr = 1'b1;
      ST_RESP:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/page_bitmap_next_fit_allocator.sv @@
// top level of the next-fit contiguous page allocator over a one-bit-per-page map
//
//  channel | direction | fields                                 | handshake
//  --------+-----------+----------------------------------------+---------------------
//  in_     | in        | kind, size_bytes, align_log            | in_valid / in_ready
//  out_    | out       | found, address                         | out_valid / out_ready
//  cfg_    | in        | index (0 usable, 1 reserved), data     | cfg_valid / cfg_ready
//
// the page map sits in a ram of 64-bit words (512 words at 32768 pages)
// after reset a clearing pass over every map word marks the reserved low pages used; no item is taken
// reinitialise: the same sweep, driven by the reserved page count, then the response step
// allocate: a setup step, then check, ram read and evaluate per word visit and per failed
// candidate, then a read and a write per word of the marked run; occupancy sets the visits
// one item at a time; a finished result waits in the output register while the next
// transfer is taken, and a stalled out_ready only holds the item in its response step
module page_bitmap_next_fit_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [pbnf_pkg::SIZE_W-1:0]    in_size_bytes,
  input  logic [pbnf_pkg::ALIGN_W-1:0]   in_align_log,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_found,
  output logic [pbnf_pkg::ADDR_W-1:0]    out_address,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbnf_pkg::REG_W-1:0]     cfg_data
);
  import pbnf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // configuration writes are always taken, one per transfer
  assign cfg_ready = 1'b1;

  // controller: handshakes and sequencing only
  pbnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: page map ram, search position, run count, marking and result registers
  pbnf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_size_bytes (in_size_bytes),
    .in_align_log  (in_align_log),
    .out_found     (out_found),
    .out_address   (out_address)
  );

endmodule

@@ sv/pbnf_checker.sv @@
// port-level checks for the allocator, bound to the top level
module pbnf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [pbnf_pkg::ADDR_W-1:0] out_address
);
  import pbnf_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_address))
    else $error("stalled result changed");

  // a failed search reports address zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_address == '0)
    else $error("failed result with non-zero address");

  // addresses are whole pages
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_address[PAGE_BYTES_LOG-1:0] == '0)
    else $error("address not page aligned");

  // one item in flight: no transfer in the cycle after one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind page_bitmap_next_fit_allocator pbnf_checker u_pbnf_checker (.*);

@@ tb/page_bitmap_next_fit_allocator_tb.sv @@
// self-checking testbench for the page bitmap next-fit allocator
`timescale 1ns / 1ps

module page_bitmap_next_fit_allocator_tb;
  import pbnf_pkg::*;

  // run bounds: the cycle limit covers a few full-map failed searches plus
  // several hundred requests at heavy pacing, many times over
  localparam int          CYCLE_LIMIT  = 5_000_000;
  localparam int          SETTLE_TICKS = 1100;   // idle ticks before the final report
  localparam int unsigned PAGE_BYTES   = 1 << PAGE_BYTES_LOG;

  // one expected response: grant flag and byte address
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } alloc_outcome_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               in_kind       = KIND_REINIT;
  logic [SIZE_W-1:0]  in_size_bytes = '0;
  logic [ALIGN_W-1:0] in_align_log  = '0;

  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               out_found;
  logic [ADDR_W-1:0]  out_address;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_USABLE;
  logic [REG_W-1:0]     cfg_data  = '0;

  // pacing knobs, percent of cycles spent idle or stalled
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  // shadow copy of the allocator: registers, used map and next-fit marker
  logic [REG_W-1:0] usable_reg;
  logic [REG_W-1:0] reserved_reg;
  bit               page_taken [PAGE_TOTAL];
  int unsigned      last_end;

  alloc_outcome_t awaited_outcomes [$];

  int n_sent     = 0;
  int n_checked  = 0;
  int n_granted  = 0;
  int n_reinits  = 0;
  int n_settings = 0;
  int n_errors   = 0;
  int cycle_count = 0;

  page_bitmap_next_fit_allocator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_size_bytes (in_size_bytes),
    .in_align_log  (in_align_log),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_address   (out_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow allocator
  // ---------------------------------------------------------------------------

  // registers above the page count behave as the full page count
  function automatic int unsigned clamp_pages(logic [REG_W-1:0] v);
    return (v > PAGE_TOTAL) ? PAGE_TOTAL : v;
  endfunction

  function automatic int unsigned align_up(int unsigned v, int unsigned a);
    return (v + (a - 1)) & ~(a - 1);
  endfunction

  // free the whole map, then take the reserved low pages; with nothing reserved
  // the marker wraps to the last page so the first search pass is empty
  function automatic void rebuild_page_map();
    int unsigned r;
    r = clamp_pages(reserved_reg);
    for (int i = 0; i < PAGE_TOTAL; i++) page_taken[i] = (i < r);
    last_end = (r == 0) ? PAGE_TOTAL - 1 : r - 1;
  endfunction

  // search [lo, hi) for an aligned free run of cnt pages; every candidate start
  // is aligned, a blocked run restarts at the next aligned page past the used one,
  // and a run that runs into hi ends the whole pass. returns the start or -1
  function automatic int find_free_run(int unsigned cnt, int unsigned lo,
                                       int unsigned hi, int unsigned stride);
    int unsigned cand;
    int unsigned pg;
    int unsigned left;
    bit          blocked;
    cand = align_up(lo, stride);
    while (cand < hi) begin
      pg      = cand;
      left    = cnt;
      blocked = 1'b0;
      while (left != 0 && !blocked) begin
        if (pg >= hi) return -1;
        if (page_taken[pg]) begin
          blocked = 1'b1;
        end else begin
          pg++;
          left--;
        end
      end
      if (!blocked) begin
        for (int unsigned p = cand; p < cand + cnt; p++) page_taken[p] = 1'b1;
        last_end = pg - 1;
        return cand;
      end
      cand = align_up(pg + 1, stride);
    end
    return -1;
  endfunction

  // response to one accepted request, updating the shadow state
  function automatic alloc_outcome_t compute_outcome(logic kind, logic [SIZE_W-1:0] size,
                                                     logic [ALIGN_W-1:0] alog);
    alloc_outcome_t res;
    int unsigned    bytes;
    int unsigned    pages;
    int unsigned    byte_addr;
    int             first;
    res.found   = 1'b0;
    res.address = '0;
    if (kind == KIND_REINIT) begin
      rebuild_page_map();
      res.found = 1'b1;
      return res;
    end
    bytes = size;
    pages = (bytes + PAGE_BYTES - 1) >> PAGE_BYTES_LOG;
    first = -1;
    // a zero-page request fails without touching the map
    if (pages != 0) begin
      first = find_free_run(pages, last_end + 1, clamp_pages(usable_reg), 1 << alog);
      // wrap: second pass from page 0 up to, not including, the marker
      if (first < 0) first = find_free_run(pages, 0, last_end, 1 << alog);
    end
    if (first >= 0) begin
      byte_addr   = first << PAGE_BYTES_LOG;
      res.found   = 1'b1;
      res.address = byte_addr[ADDR_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitors: predict on request transfers, track register writes, check responses
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready === 1'b1) begin
      awaited_outcomes.push_back(compute_outcome(in_kind, in_size_bytes, in_align_log));
      if (in_kind == KIND_REINIT) n_reinits++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready === 1'b1) begin
      case (cfg_index)
        CFG_USABLE:   usable_reg   <= cfg_data;
        CFG_RESERVED: reserved_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    alloc_outcome_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: response with nothing awaited: found %0b address 0x%0h",
                 $time, out_found, out_address);
        n_errors++;
      end else begin
        exp_res = awaited_outcomes.pop_front();
        n_checked++;
        if (exp_res.found) n_granted++;
        if (out_found !== exp_res.found) begin
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, exp_res.found, out_found);
          n_errors++;
        end
        if (out_address !== exp_res.address) begin
          $display("%0t: address mismatch: expected 0x%0h, got 0x%0h",
                   $time, exp_res.address, out_address);
          n_errors++;
        end
      end
    end
  end

  // response side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d responses outstanding",
               $time, awaited_outcomes.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request transfer; valid stays up after the transfer until the next
  // call either presents a new request or drops it for an idle gap
  task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                              input logic [ALIGN_W-1:0] alog);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_size_bytes <= size;
    in_align_log  <= alog;
    do @(posedge clk); while (in_ready !== 1'b1);
    n_sent++;
  endtask

  task automatic send_alloc(input int unsigned size, input int unsigned alog);
    send_request(KIND_ALLOC, SIZE_W'(size), ALIGN_W'(alog));
  endtask

  // stop sending and hold off until every awaited response has been checked
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_outcomes.size() != 0);
  endtask

  // both registers in back-to-back transfers; only called with the block idle
  task automatic write_registers(input logic [REG_W-1:0] usable,
                                 input logic [REG_W-1:0] reserved);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_USABLE;
    cfg_data  <= usable;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CFG_RESERVED;
    cfg_data  <= reserved;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: full map, low 16 MiB reserved, marker just below the free area
  task automatic test_after_reset();
    send_alloc(1, 0);                    // first free page after the reserved area
    send_alloc(0, 0);                    // zero pages must fail
    send_alloc(PAGE_BYTES + 1, 0);       // rounds up to two pages
    send_alloc(PAGE_BYTES, 4);           // start pushed to a 16-page boundary
    send_alloc(28'hFFFFFFF, 15);         // largest size, largest alignment
    send_alloc(1, 15);                   // no 32k-aligned start is free
    send_request(KIND_REINIT, 28'hFFFFFFF, 4'hF);
  endtask

  // nothing reserved: marker wraps to the top, first search pass is empty,
  // so the first grant is page 0 at byte address 0
  task automatic test_zero_reserved();
    wait_drained();
    write_registers(16'd64, 16'd0);
    send_request(KIND_REINIT, '0, '0);
    send_alloc(1, 0);
    send_alloc(2 * PAGE_BYTES, 1);
    send_alloc(64 * PAGE_BYTES, 0);      // runs into the end of the usable area
  endtask

  // aligned candidates around holes, and a failure at the scan end that the
  // wrap back to page 0 does not rescue
  task automatic test_alignment_and_wrap();
    wait_drained();
    write_registers(16'd256, 16'd5);
    send_request(KIND_REINIT, '0, '0);
    send_alloc(3 * PAGE_BYTES, 0);
    send_alloc(PAGE_BYTES, 3);
    send_alloc(4 * PAGE_BYTES, 2);
    send_alloc(20 * PAGE_BYTES, 4);
    send_alloc(221 * PAGE_BYTES, 0);
    send_alloc(200 * PAGE_BYTES, 0);
    send_alloc(17 * PAGE_BYTES, 0);
    send_alloc(2 * PAGE_BYTES - 7, 0);   // rounds up to two pages
  endtask

  // register extremes: smallest usable area, oversized values, top page
  task automatic test_register_extremes();
    wait_drained();
    write_registers(16'd1, 16'd1);
    send_request(KIND_REINIT, '0, '0);
    send_alloc(1, 0);
    wait_drained();
    write_registers(16'hFFFF, 16'hFFFF);  // both saturate to the page count
    send_request(KIND_REINIT, '0, '0);
    send_alloc(1, 0);                     // every page taken
    wait_drained();
    write_registers(16'd32768, 16'd32767);
    send_request(KIND_REINIT, '0, '0);
    send_alloc(PAGE_BYTES, 0);            // highest byte address
  endtask

  // mostly small aligned requests in a small or full usable area, with occasional
  // map rebuilds, empty requests, random wide sizes and wide alignments
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input bit full_map, input int n_items);
    int unsigned usable;
    int unsigned reserved;
    int unsigned max_pages;
    int unsigned pick;
    int unsigned size;
    int unsigned alog;
    wait_drained();
    if (full_map) begin
      usable   = PAGE_TOTAL;
      reserved = $urandom_range(1, 64);
    end else begin
      usable   = $urandom_range(16, 512);
      reserved = $urandom_range(1, usable / 4);
    end
    max_pages = usable / 6;
    if (max_pages > 32) max_pages = 32;
    if (max_pages == 0) max_pages = 1;
    write_registers(REG_W'(usable), REG_W'(reserved));
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    send_request(KIND_REINIT, '0, '0);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 7) begin
        send_request(KIND_REINIT, SIZE_W'($urandom), ALIGN_W'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 5)       size = 0;
        else if (pick < 10) size = $urandom & 32'h0FFF_FFFF;
        else if (pick < 20) size = $urandom_range(1, max_pages) * PAGE_BYTES;
        else size = ($urandom_range(1, max_pages) - 1) * PAGE_BYTES
                    + $urandom_range(1, PAGE_BYTES);
        pick = $urandom_range(99);
        if (pick < 70)      alog = $urandom_range(0, 2);
        else if (pick < 90) alog = $urandom_range(3, 6);
        else                alog = $urandom_range(0, 15);
        send_alloc(size, alog);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    usable_reg   = USABLE_RST;
    reserved_reg = RESERVED_RST;
    rebuild_page_map();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_zero_reserved();
    test_alignment_and_wrap();
    test_register_extremes();

    test_random_traffic(0, 0, 1'b0, 80);
    test_random_traffic(88, 0, 1'b0, 80);
    test_random_traffic(0, 88, 1'b0, 80);
    test_random_traffic(20, 20, 1'b0, 80);
    test_random_traffic(20, 20, 1'b1, 80);

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d requests (%0d map rebuilds) over %0d register settings",
             n_sent, n_reinits, n_settings);
    $display("checked %0d responses, %0d granted, in %0d cycles with four pacing mixes",
             n_checked, n_granted, cycle_count);
    if (n_errors == 0 && awaited_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
